[design/tfrp_pkg.sv]
// Shared types, codes and helper functions for the track fragment run parser.
// Used by every module of the block; no dependencies of its own.
package tfrp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CFG_RUN_FLAGS     = 2'd0;
    localparam logic [1:0] CFG_RUN_VERSION   = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD_BYTES = 2'd2;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_PACKED = 2'd2,
        KIND_END    = 2'd3
    } rec_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_SHORT    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_COUNT  = 3'd0,
        PH_OFFSET = 3'd1,
        PH_FIRST  = 3'd2,
        PH_ENTRY  = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // records that follow the first record of a queued command
    typedef enum logic [1:0] {
        TAIL_NONE       = 2'd0,
        TAIL_END_OK     = 2'd1,
        TAIL_END_SHORT  = 2'd2,
        TAIL_PACKED_END = 2'd3
    } tail_t;

    typedef struct packed {
        rec_kind_t          kind;
        status_t            status;
        logic [31:0]        count;
        logic [31:0]        offset;
        logic [31:0]        first;
        logic [31:0]        index;
        logic [31:0]        duration;
        logic [31:0]        size;
        logic [31:0]        flags;
        logic signed [32:0] cts;
        logic               last;
    } rec_t;

    typedef struct packed {
        rec_t  rec;
        tail_t tail;
    } cmd_t;

    // on: per-sample field enables (duration, size, flags, cts)
    function automatic logic [1:0] first_field(input logic [3:0] on);
        logic [1:0] f;
        f = 2'd0;
        if (on[0])      f = 2'd0;
        else if (on[1]) f = 2'd1;
        else if (on[2]) f = 2'd2;
        else if (on[3]) f = 2'd3;
        return f;
    endfunction

    function automatic logic [1:0] last_field(input logic [3:0] on);
        logic [1:0] f;
        f = 2'd0;
        if (on[3])      f = 2'd3;
        else if (on[2]) f = 2'd2;
        else if (on[1]) f = 2'd1;
        return f;
    endfunction

    // next enabled field after f; falls through to cts
    function automatic logic [1:0] next_field(input logic [3:0] on, input logic [1:0] f);
        logic [1:0] n;
        n = 2'd3;
        if (f == 2'd0 && on[1])
            n = 2'd1;
        else if (f != 2'd2 && f != 2'd3 && on[2])
            n = 2'd2;
        return n;
    endfunction

    function automatic logic [4:0] entry_bytes(input logic [3:0] on);
        logic [2:0] n;
        n = 3'(on[0]) + 3'(on[1]) + 3'(on[2]) + 3'(on[3]);
        return {n, 2'b00};
    endfunction

endpackage

[design/tfrp_front.sv]
// Front end: configuration registers, byte-level parse of the run box payload.
// Emits one command per byte that causes records. Depends on tfrp_pkg.
module tfrp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        byte_in,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              push,
    output tfrp_pkg::cmd_t    cmd
);

    logic [23:0]      flags_reg;
    logic [7:0]       version_reg;
    logic [31:0]      payload_reg;

    tfrp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       pos_reg, pos_next;
    logic [23:0]      acc_reg, acc_next;
    logic [31:0]      left_reg, left_next;
    logic [31:0]      total_reg, total_next;
    logic [31:0]      done_reg, done_next;
    logic [1:0]       field_reg, field_next;
    logic [31:0]      dur_reg, dur_next;
    logic [31:0]      size_reg, size_next;
    logic [31:0]      flg_reg, flg_next;
    logic [31:0]      offset_reg, offset_next;
    logic [31:0]      first_reg, first_next;

    logic [3:0]       on;
    logic [1:0]       ff, lf;
    logic [4:0]       ebytes;
    logic             active, conflict, hdr_short, ent_short, abort, shift, word_done;
    logic [31:0]      w, left_dec, done_inc;
    logic             hdr_fin, hdr_cont, too_big, ent_emit, run_end;
    logic [31:0]      hdr_count, hdr_off, hdr_first;
    logic signed [32:0] cts_w;
    logic             cfg_hit;

    assign on     = flags_reg[11:8];
    assign ff     = tfrp_pkg::first_field(on);
    assign lf     = tfrp_pkg::last_field(on);
    assign ebytes = tfrp_pkg::entry_bytes(on);

    assign active    = take && (phase_reg != tfrp_pkg::PH_DONE);
    assign conflict  = (phase_reg == tfrp_pkg::PH_COUNT) && flags_reg[2] && flags_reg[10];
    assign hdr_short = (phase_reg != tfrp_pkg::PH_ENTRY) && (left_reg < 32'd4);
    assign ent_short = (phase_reg == tfrp_pkg::PH_ENTRY) && (field_reg == ff)
                       && (left_reg < {27'd0, ebytes});
    assign abort     = active && (pos_reg == 2'd0) && (conflict || hdr_short || ent_short);
    assign shift     = active && !abort;
    assign word_done = shift && (pos_reg == 2'd3);
    assign w         = {acc_reg, byte_in};
    assign left_dec  = left_reg - 32'd1;
    assign done_inc  = done_reg + 32'd1;
    assign run_end   = (done_inc == total_reg);

    assign hdr_fin = word_done &&
                     (((phase_reg == tfrp_pkg::PH_COUNT) && !flags_reg[0] && !flags_reg[2]) ||
                      ((phase_reg == tfrp_pkg::PH_OFFSET) && !flags_reg[2]) ||
                      (phase_reg == tfrp_pkg::PH_FIRST));
    assign hdr_count = (phase_reg == tfrp_pkg::PH_COUNT)  ? w : total_reg;
    assign hdr_off   = (phase_reg == tfrp_pkg::PH_OFFSET) ? w : offset_reg;
    assign hdr_first = (phase_reg == tfrp_pkg::PH_FIRST)  ? w : first_reg;
    // exact 4 * count against remaining bytes, no wrap
    assign too_big   = {hdr_count, 2'b00} > {2'b00, left_dec};
    assign hdr_cont  = (on != 4'd0) && !too_big && (hdr_count != 32'd0);

    assign ent_emit = word_done && (phase_reg == tfrp_pkg::PH_ENTRY) && (field_reg == lf);
    assign cts_w    = (version_reg != 8'd0 && w[31]) ? {1'b1, w} : {1'b0, w};

    assign cfg_hit = cfg_we && (cfg_index == tfrp_pkg::CFG_RUN_FLAGS ||
                                cfg_index == tfrp_pkg::CFG_RUN_VERSION ||
                                cfg_index == tfrp_pkg::CFG_PAYLOAD_BYTES);

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        done_next   = done_reg;
        field_next  = field_reg;
        dur_next    = dur_reg;
        size_next   = size_reg;
        flg_next    = flg_reg;
        offset_next = offset_reg;
        first_next  = first_reg;
        if (abort)
        begin
            phase_next = tfrp_pkg::PH_DONE;
        end
        else if (shift)
        begin
            acc_next  = w[23:0];
            left_next = left_dec;
            pos_next  = pos_reg + 2'd1;
            if (word_done)
            begin
                unique case (phase_reg)
                    tfrp_pkg::PH_COUNT:
                    begin
                        total_next = w;
                        if (flags_reg[0])
                            phase_next = tfrp_pkg::PH_OFFSET;
                        else if (flags_reg[2])
                            phase_next = tfrp_pkg::PH_FIRST;
                    end
                    tfrp_pkg::PH_OFFSET:
                    begin
                        offset_next = w;
                        if (flags_reg[2])
                            phase_next = tfrp_pkg::PH_FIRST;
                    end
                    tfrp_pkg::PH_FIRST:
                    begin
                        first_next = w;
                    end
                    tfrp_pkg::PH_ENTRY:
                    begin
                        if (field_reg == 2'd0) dur_next  = w;
                        if (field_reg == 2'd1) size_next = w;
                        if (field_reg == 2'd2) flg_next  = w;
                        if (field_reg == lf)
                        begin
                            done_next  = done_inc;
                            field_next = ff;
                            if (run_end)
                                phase_next = tfrp_pkg::PH_DONE;
                        end
                        else
                        begin
                            field_next = tfrp_pkg::next_field(on, field_reg);
                        end
                    end
                    tfrp_pkg::PH_DONE:
                    begin
                    end
                endcase
                if (hdr_fin)
                begin
                    phase_next = hdr_cont ? tfrp_pkg::PH_ENTRY : tfrp_pkg::PH_DONE;
                    if (hdr_cont)
                        field_next = ff;
                end
            end
        end
    end

    // command to the queue
    always_comb
    begin
        push = abort || hdr_fin || ent_emit;
        cmd  = '0;
        if (abort)
        begin
            cmd.rec.kind   = tfrp_pkg::KIND_END;
            cmd.rec.status = conflict ? tfrp_pkg::ST_CONFLICT : tfrp_pkg::ST_SHORT;
            cmd.rec.last   = 1'b1;
            cmd.tail       = tfrp_pkg::TAIL_NONE;
        end
        else if (hdr_fin)
        begin
            cmd.rec.kind   = tfrp_pkg::KIND_HEADER;
            cmd.rec.count  = hdr_count;
            cmd.rec.offset = hdr_off;
            cmd.rec.first  = hdr_first;
            if (on == 4'd0)
                cmd.tail = tfrp_pkg::TAIL_PACKED_END;
            else if (too_big)
                cmd.tail = tfrp_pkg::TAIL_END_SHORT;
            else if (hdr_count == 32'd0)
                cmd.tail = tfrp_pkg::TAIL_END_OK;
            else
                cmd.tail = tfrp_pkg::TAIL_NONE;
        end
        else if (ent_emit)
        begin
            cmd.rec.kind     = tfrp_pkg::KIND_SAMPLE;
            cmd.rec.index    = done_reg;
            cmd.rec.duration = on[0] ? dur_next  : 32'd0;
            cmd.rec.size     = on[1] ? size_next : 32'd0;
            cmd.rec.flags    = on[2] ? flg_next  : 32'd0;
            cmd.rec.cts      = on[3] ? cts_w     : 33'sd0;
            cmd.tail         = run_end ? tfrp_pkg::TAIL_END_OK : tfrp_pkg::TAIL_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            version_reg <= '0;
            payload_reg <= '0;
            phase_reg   <= tfrp_pkg::PH_COUNT;
            pos_reg     <= '0;
            acc_reg     <= '0;
            left_reg    <= '0;
            total_reg   <= '0;
            done_reg    <= '0;
            field_reg   <= '0;
            dur_reg     <= '0;
            size_reg    <= '0;
            flg_reg     <= '0;
            offset_reg  <= '0;
            first_reg   <= '0;
        end
        else if (cfg_hit)
        begin
            if (cfg_index == tfrp_pkg::CFG_RUN_FLAGS)
                flags_reg <= cfg_data[23:0];
            if (cfg_index == tfrp_pkg::CFG_RUN_VERSION)
                version_reg <= cfg_data[7:0];
            if (cfg_index == tfrp_pkg::CFG_PAYLOAD_BYTES)
                payload_reg <= cfg_data;
            // any register write restarts the parse
            phase_reg  <= tfrp_pkg::PH_COUNT;
            pos_reg    <= '0;
            acc_reg    <= '0;
            left_reg   <= (cfg_index == tfrp_pkg::CFG_PAYLOAD_BYTES) ? cfg_data : payload_reg;
            total_reg  <= '0;
            done_reg   <= '0;
            field_reg  <= '0;
            dur_reg    <= '0;
            size_reg   <= '0;
            flg_reg    <= '0;
            offset_reg <= '0;
            first_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            left_reg   <= left_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
            field_reg  <= field_next;
            dur_reg    <= dur_next;
            size_reg   <= size_next;
            flg_reg    <= flg_next;
            offset_reg <= offset_next;
            first_reg  <= first_next;
        end
    end

endmodule

[design/tfrp_queue.sv]
// Command queue between the parse front end and the record back end.
// Small register FIFO; depends on tfrp_pkg.
module tfrp_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tfrp_pkg::cmd_t    cmd_in,
    input  logic              pop,
    output tfrp_pkg::cmd_t    head,
    output logic              nonempty,
    output logic              full
);

    tfrp_pkg::cmd_t                mem [tfrp_pkg::QUEUE_DEPTH];
    logic [tfrp_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [tfrp_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                          do_push, do_pop;

    assign nonempty = (cnt_reg != '0);
    assign full     = (cnt_reg == tfrp_pkg::QCNT_W'(tfrp_pkg::QUEUE_DEPTH));
    assign head     = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[design/tfrp_back.sv]
// Back end: expands each queued command into one to three records and
// drives the registered output stage. Depends on tfrp_pkg.
module tfrp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  tfrp_pkg::cmd_t    head,
    input  logic              nonempty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output tfrp_pkg::rec_t    out_rec
);

    logic [1:0]      step_reg;
    logic            valid_reg;
    tfrp_pkg::rec_t  rec_reg;
    tfrp_pkg::rec_t  rec_now, end_rec, packed_rec;
    logic            final_step, load;

    assign load = nonempty && (!valid_reg || out_ready);
    assign pop  = load && final_step;

    always_comb
    begin
        end_rec        = '0;
        end_rec.kind   = tfrp_pkg::KIND_END;
        end_rec.status = (head.tail == tfrp_pkg::TAIL_END_SHORT) ? tfrp_pkg::ST_SHORT
                                                                 : tfrp_pkg::ST_OK;
        end_rec.last   = 1'b1;

        packed_rec       = '0;
        packed_rec.kind  = tfrp_pkg::KIND_PACKED;
        packed_rec.count = head.rec.count;

        // step 0: the command's own record, then the tail records in order
        if (step_reg == 2'd0)
        begin
            rec_now    = head.rec;
            final_step = (head.tail == tfrp_pkg::TAIL_NONE);
        end
        else if (step_reg == 2'd1 && head.tail == tfrp_pkg::TAIL_PACKED_END)
        begin
            rec_now    = packed_rec;
            final_step = 1'b0;
        end
        else
        begin
            rec_now    = end_rec;
            final_step = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= rec_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                step_reg <= final_step ? 2'd0 : step_reg + 2'd1;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

[design/track_fragment_run_parser_core.sv]
// Top level of the track fragment run parser: front end, command queue, back end.
// Depends on tfrp_pkg, tfrp_front, tfrp_queue and tfrp_back.
//
// The block takes one payload byte per cycle while s_tready is high. Bytes
// shift into a word accumulator in the front end; a byte that completes the
// header or a sample entry, or that hits an error, pushes one command into a
// four-entry queue. The back end turns each command into one to three records
// and sends one record per cycle while m_tready is high, through a registered
// output. A byte that ends the run can yield three records; the queue absorbs
// these; s_tready drops only while the queue is full. Commands pass the queue
// and records the output register. Configuration writes restart the parse.
module track_fragment_run_parser_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] payload_byte
    output logic          m_tvalid,
    input  logic          m_tready,
    // [1:0] status, [33:2] run sample total, [65:34] base offset word,
    // [97:66] lead sample flags, [129:98] sample_index, [161:130] duration,
    // [193:162] sample_size, [225:194] sample_flags, [258:226] composition offset,
    // rest zero
    output logic [263:0]  m_tdata,
    output logic [1:0]    m_tuser,   // [1:0] record_kind
    output logic          m_tlast,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    logic            take, push, pop, nonempty, full;
    tfrp_pkg::cmd_t  cmd, head;
    tfrp_pkg::rec_t  rec;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    tfrp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .byte_in   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .cmd       (cmd)
    );

    tfrp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .cmd_in   (cmd),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty),
        .full     (full)
    );

    tfrp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .nonempty  (nonempty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (rec)
    );

    assign m_tdata = {5'd0, rec.cts, rec.flags, rec.size, rec.duration, rec.index,
                      rec.first, rec.offset, rec.count, rec.status};
    assign m_tuser = rec.kind;
    assign m_tlast = rec.last;

endmodule

[design/tfrp_checker.sv]
// Port-level checks on the record stream of the run parser, bound to the top level.
// Depends on tfrp_pkg and track_fragment_run_parser_core.
module tfrp_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [263:0]  m_tdata,
    input  logic [1:0]    m_tuser,
    input  logic          m_tlast
);

    // a stalled item holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("record changed while stalled");

    // only the end record closes the box
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == tfrp_pkg::KIND_END)))
        else $error("tlast does not match end record");

    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != tfrp_pkg::KIND_END) |-> (m_tdata[1:0] == tfrp_pkg::ST_OK))
        else $error("status set outside end record");

    // a packed record is always followed by its end record
    a_packed_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == tfrp_pkg::KIND_PACKED)
        |=> !m_tvalid || (m_tuser == tfrp_pkg::KIND_END))
        else $error("packed record not followed by end record");

endmodule

bind track_fragment_run_parser_core tfrp_checker u_tfrp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
